### hdl/tone_pattern_sequencer_defines.svh
// Assertion macros for the tone pattern sequencer
`ifndef TONE_PATTERN_SEQUENCER_DEFINES_SVH
`define TONE_PATTERN_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tone_pattern_sequencer: same-cycle check failed");
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tone_pattern_sequencer: next-cycle check failed");
`else
`define TPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/tps_pkg.sv
// Types, codes and pattern ROM of the tone pattern sequencer
package tps_pkg;

	localparam int NUM_PATTERNS_DEF = 5;
	localparam int MAX_STEPS_DEF    = 16;
	localparam int NCH              = 2;
	localparam int NOUT             = 6;

	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_STOP  = 2'd1;
	localparam logic [1:0] FN_TICK  = 2'd2;

	localparam logic [3:0] VOL_MAX  = 4'd15;

	typedef enum logic [1:0] {
		ACT_TRIGGER = 2'd0,
		ACT_SILENCE = 2'd1,
		ACT_MUTE    = 2'd2
	} act_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] channel_sel;
		logic [7:0] pattern_num;
		logic [7:0] volume_req;
		logic       sfx_active;
		logic [3:0] sfx_mute_mask;
	} item_t;

	typedef struct packed {
		logic        channel;
		act_t        action;
		logic [10:0] freq;
		logic [3:0]  volume;
		logic [3:0]  mask;
	} cmd_t;

	typedef struct packed {
		logic [2:0]            cnt;
		cmd_t [NOUT-1:0]       cmd;
	} batch_t;

	typedef struct packed {
		logic       active;
		logic [2:0] pattern;
		logic [4:0] step;
		logic [7:0] frames;
		logic [3:0] volume;
		logic       stolen;
		logic       sounding;
		logic [3:0] saved;
	} chan_state_t;

	typedef struct packed {
		logic [10:0] freq;
		logic [7:0]  dur;
	} step_t;

	typedef struct packed {
		chan_state_t st;
		logic        fire;
		cmd_t        cmd;
	} play_t;

	function automatic cmd_t mk_cmd(logic ch, act_t act, logic [10:0] freq,
		logic [3:0] vol, logic [3:0] mask);
		cmd_t c;
		c.channel = ch;
		c.action  = act;
		c.freq    = freq;
		c.volume  = vol;
		c.mask    = mask;
		return c;
	endfunction

	function automatic logic [4:0] rom_count(logic [2:0] p);
		logic [4:0] r;
		case (p)
			3'd0:    r = 5'd1;
			3'd1:    r = 5'd4;
			3'd2:    r = 5'd2;
			3'd3:    r = 5'd16;
			3'd4:    r = 5'd16;
			default: r = 5'd1;
		endcase
		return r;
	endfunction

	function automatic logic rom_loop(logic [2:0] p);
		return p == 3'd2;
	endfunction

	// entries past a pattern's length read as zero frequency, zero duration
	function automatic step_t rom_step(logic [2:0] p, logic [3:0] s);
		step_t e;
		e = '0;
		case (p)
			3'd0: begin
				if (s == 4'd0) e = '{freq: 11'd1760, dur: 8'd20};
			end
			3'd1: begin
				case (s)
					4'd0:    e = '{freq: 11'd1810, dur: 8'd5};
					4'd1:    e = '{freq: 11'd1796, dur: 8'd5};
					4'd2:    e = '{freq: 11'd1781, dur: 8'd5};
					4'd3:    e = '{freq: 11'd1769, dur: 8'd5};
					default: e = '0;
				endcase
			end
			3'd2: begin
				if (s == 4'd0) e = '{freq: 11'd1760, dur: 8'd15};
				else if (s == 4'd1) e = '{freq: 11'd1812, dur: 8'd15};
			end
			3'd3: begin
				e = s[0] ? '{freq: 11'd1812, dur: 8'd6} : '{freq: 11'd1760, dur: 8'd6};
			end
			3'd4: begin
				e = s[0] ? '{freq: 11'd0, dur: 8'd16} : '{freq: 11'd1915, dur: 8'd8};
			end
			default: begin
				if (s == 4'd0) e = '{freq: 11'd0, dur: 8'd1};
			end
		endcase
		return e;
	endfunction

	// load the current step: set its duration, then trigger or silence
	function automatic play_t play_step(chan_state_t s, logic ch);
		step_t e;
		play_t r;
		e = rom_step(s.pattern, s.step[3:0]);
		r.st = s;
		r.fire = 1'b0;
		r.cmd = '0;
		r.st.frames = e.dur;
		if (e.freq == 11'd0) begin
			if (s.sounding) begin
				r.fire = 1'b1;
				r.cmd = mk_cmd(ch, ACT_SILENCE, 11'd0, 4'd0, 4'd0);
				r.st.sounding = 1'b0;
			end
		end else begin
			r.fire = 1'b1;
			r.cmd = mk_cmd(ch, ACT_TRIGGER, e.freq, s.volume, 4'd0);
			r.st.sounding = 1'b1;
		end
		return r;
	endfunction

endpackage

### hdl/tps_in_if.sv
// Request channel: start, stop and frame tick beats
interface tps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] channel_sel;
	logic [7:0] pattern_num;
	logic [7:0] volume_req;
	logic       sfx_active;
	logic [3:0] sfx_mute_mask;

	modport source (
		output valid, func, channel_sel, pattern_num, volume_req, sfx_active, sfx_mute_mask,
		input  ready
	);
	modport sink (
		input  valid, func, channel_sel, pattern_num, volume_req, sfx_active, sfx_mute_mask,
		output ready
	);
endinterface

### hdl/tps_out_if.sv
// Command channel: trigger, silence and mute-mask beats
interface tps_out_if;
	logic        valid;
	logic        ready;
	logic        out_channel;
	logic [1:0]  action;
	logic [10:0] tone_freq;
	logic [3:0]  tone_volume;
	logic [3:0]  mute_mask;
	logic        last;

	modport source (
		output valid, out_channel, action, tone_freq, tone_volume, mute_mask, last,
		input  ready
	);
	modport sink (
		input  valid, out_channel, action, tone_freq, tone_volume, mute_mask, last,
		output ready
	);
endinterface

### hdl/tps_seq.sv
// Channel state and the single-pass command generator
module tps_seq #(
	parameter int NUM_PATTERNS = tps_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_STEPS    = tps_pkg::MAX_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  tps_pkg::item_t item,
	output tps_pkg::batch_t batch
);
	import tps_pkg::*;

	chan_state_t [NCH-1:0] state_q;
	logic [3:0]            gmute_q;

	chan_state_t [NCH-1:0] st;
	logic [3:0]            gm;
	cmd_t [NOUT-1:0]       cmds;
	logic [2:0]            n;
	logic                  ch;
	logic [NCH-1:0]        owns;
	logic [2:0]            pat;
	logic [3:0]            vol;
	logic [4:0]            nxt_step;
	logic [4:0]            cnt;
	logic [4:0]            lim;
	step_t                 e;
	play_t                 pr;
	logic                  play;

	always_comb begin
		st = state_q;
		gm = gmute_q;
		cmds = '0;
		n = 3'd0;
		e = '0;
		pr = '0;
		play = 1'b0;
		nxt_step = '0;
		cnt = '0;
		lim = '0;
		ch = (item.channel_sel != 8'd1);
		owns = {NCH{item.sfx_active}} & item.sfx_mute_mask[NCH-1:0];
		pat = (item.pattern_num >= 8'(NUM_PATTERNS)) ? 3'd0 : item.pattern_num[2:0];
		vol = (item.volume_req > 8'(VOL_MAX)) ? VOL_MAX : item.volume_req[3:0];

		unique case (item.func)
			FN_START: begin
				if (st[ch].active) begin
					if (!owns[ch] && st[ch].sounding) begin
						cmds[n] = mk_cmd(ch, ACT_SILENCE, 11'd0, 4'd0, 4'd0);
						n = n + 3'd1;
					end
					gm = st[ch].saved;
					cmds[n] = mk_cmd(ch, ACT_MUTE, 11'd0, 4'd0, gm | item.sfx_mute_mask);
					n = n + 3'd1;
				end
				st[ch].pattern = pat;
				st[ch].volume = vol;
				st[ch].step = 5'd0;
				st[ch].stolen = 1'b0;
				st[ch].sounding = 1'b0;
				st[ch].saved = gm;
				gm = gm | (4'd1 << ch);
				cmds[n] = mk_cmd(ch, ACT_MUTE, 11'd0, 4'd0, gm | item.sfx_mute_mask);
				n = n + 3'd1;
				st[ch].active = 1'b1;
				if (!owns[ch]) begin
					pr = play_step(st[ch], ch);
					st[ch] = pr.st;
					if (pr.fire) begin
						cmds[n] = pr.cmd;
						n = n + 3'd1;
					end
				end else begin
					st[ch].stolen = 1'b1;
				end
			end
			FN_STOP: begin
				if (st[ch].active) begin
					st[ch].active = 1'b0;
					if (!owns[ch] && st[ch].sounding) begin
						cmds[n] = mk_cmd(ch, ACT_SILENCE, 11'd0, 4'd0, 4'd0);
						n = n + 3'd1;
					end
					st[ch].sounding = 1'b0;
					gm = st[ch].saved;
					cmds[n] = mk_cmd(ch, ACT_MUTE, 11'd0, 4'd0, gm | item.sfx_mute_mask);
					n = n + 3'd1;
				end
			end
			FN_TICK: begin
				for (int c = 0; c < NCH; c++) begin
					play = 1'b0;
					if (st[c].active) begin
						if (owns[c]) begin
							st[c].stolen = 1'b1;
						end else begin
							// sound effects released the channel: retrigger current tone
							if (st[c].stolen) begin
								e = rom_step(st[c].pattern, st[c].step[3:0]);
								st[c].stolen = 1'b0;
								if (st[c].frames != 8'd0 && e.freq != 11'd0) begin
									cmds[n] = mk_cmd(1'(c), ACT_TRIGGER, e.freq, st[c].volume,
										4'd0);
									n = n + 3'd1;
									st[c].sounding = 1'b1;
								end
							end
							if (st[c].frames != 8'd0) begin
								st[c].frames = st[c].frames - 8'd1;
								if (st[c].frames == 8'd0) begin
									nxt_step = st[c].step + 5'd1;
									cnt = rom_count(st[c].pattern);
									lim = (cnt > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : cnt;
									if (nxt_step >= lim) begin
										if (rom_loop(st[c].pattern)) begin
											st[c].step = 5'd0;
											play = 1'b1;
										end else begin
											st[c].step = nxt_step;
											if (st[c].sounding) begin
												cmds[n] = mk_cmd(1'(c), ACT_SILENCE, 11'd0,
													4'd0, 4'd0);
												n = n + 3'd1;
												st[c].sounding = 1'b0;
											end
											st[c].active = 1'b0;
											gm = st[c].saved;
											cmds[n] = mk_cmd(1'(c), ACT_MUTE, 11'd0, 4'd0,
												gm | item.sfx_mute_mask);
											n = n + 3'd1;
										end
									end else begin
										st[c].step = nxt_step;
										play = 1'b1;
									end
								end
							end
						end
					end
					if (play) begin
						pr = play_step(st[c], 1'(c));
						st[c] = pr.st;
						if (pr.fire) begin
							cmds[n] = pr.cmd;
							n = n + 3'd1;
						end
					end
				end
			end
			default: ;
		endcase

		batch.cnt = n;
		batch.cmd = cmds;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			gmute_q <= '0;
		end else if (go) begin
			state_q <= st;
			gmute_q <= gm;
		end
	end

endmodule

### hdl/tps_drain.sv
// Command buffer: holds one item's commands and sends them one beat per cycle while rsp.ready is high
module tps_drain (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tps_pkg::batch_t  batch,
	output logic             load_ok,
	tps_out_if.source        rsp
);
	import tps_pkg::*;

	cmd_t [NOUT-1:0] cmds_q;
	logic [2:0]      cnt_q;
	logic            pop;

	assign rsp.valid       = (cnt_q != 3'd0);
	assign pop             = rsp.valid && rsp.ready;
	// free now, or its final command leaves this cycle
	assign load_ok         = (cnt_q == 3'd0) || (cnt_q == 3'd1 && rsp.ready);

	assign rsp.out_channel = cmds_q[0].channel;
	assign rsp.action      = cmds_q[0].action;
	assign rsp.tone_freq   = cmds_q[0].freq;
	assign rsp.tone_volume = cmds_q[0].volume;
	assign rsp.mute_mask   = cmds_q[0].mask;
	assign rsp.last        = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmds_q <= batch.cmd;
		end else if (pop) begin
			cmds_q <= {cmd_t'('0), cmds_q[NOUT-1:1]};
		end
	end

endmodule

### hdl/tone_pattern_sequencer.sv
// Two-channel beep pattern sequencer. Each request beat (start, stop or frame tick) is
// registered, then resolved combinationally against the channel state into zero to six
// commands, which go into a six-entry command buffer and leave on rsp one beat per cycle
// while rsp.ready is high, the final one marked by last. A request is taken every cycle
// while the buffer can accept; the sustained rate is set by the command buffer's single
// output port, as an item's commands leave one at a time and the next item loads only once
// the buffer is empty or its final command is leaving. A request is registered at the input,
// and its commands in the buffer before reaching rsp. No clearing pass follows reset.
`include "tone_pattern_sequencer_defines.svh"
module tone_pattern_sequencer #(
	parameter int NUM_PATTERNS = tps_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_STEPS    = tps_pkg::MAX_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tps_in_if.sink    req,
	tps_out_if.source rsp
);
	import tps_pkg::*;

	logic   valid_s1;
	item_t  item_s1;
	logic   load_ok;
	logic   go;
	batch_t batch;

	assign go        = valid_s1 && load_ok;
	assign req.ready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.func          <= req.func;
			item_s1.channel_sel   <= req.channel_sel;
			item_s1.pattern_num   <= req.pattern_num;
			item_s1.volume_req    <= req.volume_req;
			item_s1.sfx_active    <= req.sfx_active;
			item_s1.sfx_mute_mask <= req.sfx_mute_mask;
		end
	end

	tps_seq #(
		.NUM_PATTERNS(NUM_PATTERNS),
		.MAX_STEPS   (MAX_STEPS)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.item  (item_s1),
		.batch (batch)
	);

	tps_drain u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (go),
		.batch  (batch),
		.load_ok(load_ok),
		.rsp    (rsp)
	);

	// a taken request is always registered for processing in the next cycle
	`TPS_ASSERT_NEXT(a_req_reg, clk, arst_n, req.valid && req.ready, valid_s1)
	// once the final command of an item leaves and nothing is loaded, output goes idle
	`TPS_ASSERT_NEXT(a_last_empties, clk, arst_n, rsp.valid && rsp.ready && rsp.last && !go, !rsp.valid)
	// the sequencer never triggers a tone at frequency zero
	`TPS_ASSERT_SAME(a_trig_freq, clk, arst_n, rsp.valid && rsp.action == ACT_TRIGGER, rsp.tone_freq != 11'd0)
	// silence and mute commands carry no tone settings
	`TPS_ASSERT_SAME(a_nontrig_zero, clk, arst_n, rsp.valid && rsp.action != ACT_TRIGGER, rsp.tone_freq == 11'd0 && rsp.tone_volume == 4'd0)

endmodule
